[rtl/core/sdp_pkg.sv]
// shared types, constants and helper functions of the sky dome pixel lookup
// no dependencies; used by every module under rtl/core
package sdp_pkg;

	// fixed formats
	localparam int IN_W     = 16;
	localparam int DIM_W    = 13;
	localparam int IDX_W    = 12;
	localparam int RGB_W    = 24;
	localparam int CFG_W    = 24;
	localparam int ANG_W    = 33;
	localparam int DIM_BITS = 12;
	localparam int MAX_STAGES = 24;
	localparam int CORDIC_STAGES_DEF = 16;

	// chain widths: azimuth, zenith and rotation vectors
	localparam int AZ_W  = 34;
	localparam int ZEN_W = 35;
	localparam int ROT_W = 30;

	// gain correction 0.60725293 in Q30 and a quarter turn in binary angle units
	localparam logic [29:0] KINV_U = 30'd652032874;
	localparam logic signed [30:0] KINV_S = 31'sd652032874;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 33'sd1073741824;

	// largest index the image addressing allows
	localparam logic signed [17:0] IDX_LIM = 18'((1 << DIM_BITS) - 1);

	// register indexes
	localparam logic [1:0] REG_TEXTURE = 2'd0;
	localparam logic [1:0] REG_COLUMNS = 2'd1;
	localparam logic [1:0] REG_ROWS    = 2'd2;
	localparam logic [1:0] REG_RGB     = 2'd3;

	// arctangent table, atan(2^-i) in binary angle units (2^31 = pi)
	localparam logic [31:0] ATAN_TAB [0:MAX_STAGES-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// what a cell does with its vector
	typedef enum logic [1:0] {
		MODE_AZ,
		MODE_ZEN,
		MODE_ROT
	} cordic_mode_t;

	// per-item flags and the z component travelling beside the vectors
	typedef struct packed {
		logic                    fallback;
		logic                    flip;
		logic                    zero;
		logic signed [IN_W-1:0]  z;
	} side_t;

	// clamp a signed pixel index into the image
	function automatic logic [IDX_W-1:0] clamp_index(input logic signed [15:0] v,
		input logic [DIM_W-1:0] dim);
		logic signed [17:0] hi;
		logic signed [17:0] vv;
		hi = $signed({5'b0, dim}) - 18'sd1;
		if (hi > IDX_LIM) hi = IDX_LIM;
		if (hi < 18'sd0) hi = 18'sd0;
		vv = {{2{v[15]}}, v};
		if (vv < 18'sd0) vv = 18'sd0;
		if (vv > hi) vv = hi;
		return vv[IDX_W-1:0];
	endfunction

endpackage

[rtl/core/sky_dome_direction_to_pixel.sv]
// top level: ray direction to equidistant fisheye sky pixel, fully pipelined
// depends on sdp_pkg, sdp_cordic_chain and sdp_cordic_cell
//
// channel   ports                                              transfer
// command   start, busy, dir_x, dir_y, dir_z                   start & !busy at clk rise
// result    done, use_fallback, pixel_column, pixel_row,       done high for one cycle
//           fallback_color
// config    cfg_we, cfg_index, cfg_data                        cfg_we at clk rise
//
// one item per clock; busy is never raised
// stages: azimuth, zenith and back-rotation chains of CORDIC_STAGES cells each,
//   plus entry, horizontal length, pixel radius, gain correction and output
// arst_n clears all valid flags and the configuration registers
// results cannot be held off: each sits on the result ports for one cycle
module sky_dome_direction_to_pixel import sdp_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [IN_W-1:0]  dir_x,
	input  logic signed [IN_W-1:0]  dir_y,
	input  logic signed [IN_W-1:0]  dir_z,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output logic                    done,
	output logic                    use_fallback,
	output logic [IDX_W-1:0]        pixel_column,
	output logic [IDX_W-1:0]        pixel_row,
	output logic [RGB_W-1:0]        fallback_color
);

	localparam int N = CORDIC_STAGES;

	// configuration registers
	logic              tex_en_q;
	logic [DIM_W-1:0]  cols_q, rows_q;
	logic [RGB_W-1:0]  rgb_q;

	// entry stage
	logic                   accept;
	logic                   valid_s1;
	logic signed [AZ_W-1:0] vx_s1, vy_s1;
	side_t                  side_s1;
	logic signed [AZ_W-1:0] xe, ye;
	logic                   flip;

	// azimuth chain outputs
	logic                    az_valid;
	logic signed [AZ_W-1:0]  az_x, az_y;
	logic signed [ANG_W-1:0] az_ang;
	logic [N-1:0]            az_dirs;
	side_t                   az_side;

	// horizontal length stage
	logic [30:0]    vxc;
	logic [60:0]    prod_h;
	logic           valid_s2;
	logic [30:0]    h_s2;
	logic [N-1:0]   dirs_s2;
	side_t          side_s2;
	logic signed [ZEN_W-1:0] zen_x0, zen_y0;

	// zenith chain outputs
	logic                    zen_valid;
	logic signed [ZEN_W-1:0] zen_x, zen_y;
	logic signed [ANG_W-1:0] zen_ang;
	logic [N-1:0]            zen_dirs;
	side_t                   zen_side;

	// pixel radius stage
	logic [30:0]     zd;
	logic [11:0]     cc, cr, radius;
	logic [42:0]     prod_p;
	logic            valid_s3;
	logic [28:0]     p_s3;
	logic [N-1:0]    dirs_s3;
	side_t           side_s3;

	// rotation chain outputs
	logic                    rot_valid;
	logic signed [ROT_W-1:0] rot_x, rot_y;
	logic signed [ANG_W-1:0] rot_ang;
	logic [N-1:0]            rot_dirs;
	side_t                   rot_side;

	// gain correction stage
	logic signed [ROT_W-1:0] fx, fy;
	logic                    valid_s4;
	logic signed [60:0]      prod_x_s4, prod_y_s4;
	side_t                   side_s4;

	// output stage
	logic signed [15:0]  offc, offr, col_v, row_v;
	logic                done_q, fb_q;
	logic [IDX_W-1:0]    col_q, row_q;
	logic [RGB_W-1:0]    color_q;

	// truncating shift by 46 toward zero
	function automatic logic signed [15:0] trunc46(input logic signed [60:0] v);
		logic [60:0] mag;
		logic [15:0] r;
		mag = v[60] ? 61'(-v) : 61'(v);
		r   = {1'b0, mag[60:46]};
		return v[60] ? $signed(-r) : $signed(r);
	endfunction

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_en_q <= 1'b0;
			cols_q   <= '0;
			rows_q   <= '0;
			rgb_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEXTURE: tex_en_q <= cfg_data[0];
				REG_COLUMNS: cols_q   <= cfg_data[DIM_W-1:0];
				REG_ROWS:    rows_q   <= cfg_data[DIM_W-1:0];
				REG_RGB:     rgb_q    <= cfg_data[RGB_W-1:0];
				default:     tex_en_q <= tex_en_q;
			endcase
		end
	end

	// entry: scale to Q.29 and fold the left half plane onto the right
	always_comb begin
		xe   = AZ_W'(dir_x) <<< 14;
		ye   = AZ_W'(dir_y) <<< 14;
		flip = dir_x[IN_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		vx_s1            <= flip ? -xe : xe;
		vy_s1            <= flip ? -ye : ye;
		side_s1.fallback <= !tex_en_q || dir_z[IN_W-1];
		side_s1.flip     <= flip;
		side_s1.zero     <= (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
		side_s1.z        <= dir_z;
	end

	// azimuth vectoring, records the turn of each cell
	sdp_cordic_chain #(.W(AZ_W), .N(N), .MODE(MODE_AZ)) u_az (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_x      (vx_s1),
		.in_y      (vy_s1),
		.in_ang    ('0),
		.in_dirs   ('0),
		.in_side   (side_s1),
		.out_valid (az_valid),
		.out_x     (az_x),
		.out_y     (az_y),
		.out_ang   (az_ang),
		.out_dirs  (az_dirs),
		.out_side  (az_side)
	);

	// horizontal length with gain removed
	always_comb begin
		vxc    = az_x[AZ_W-1] ? 31'd0 : az_x[30:0];
		prod_h = vxc * KINV_U;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= az_valid;
		end
	end

	always_ff @(posedge clk) begin
		h_s2    <= prod_h[60:30];
		dirs_s2 <= az_dirs;
		side_s2 <= az_side;
	end

	assign zen_x0 = ZEN_W'(side_s2.z) <<< 14;
	assign zen_y0 = $signed(ZEN_W'(h_s2));

	// zenith vectoring on (z, h), accumulates the angle
	sdp_cordic_chain #(.W(ZEN_W), .N(N), .MODE(MODE_ZEN)) u_zen (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_x      (zen_x0),
		.in_y      (zen_y0),
		.in_ang    ('0),
		.in_dirs   (dirs_s2),
		.in_side   (side_s2),
		.out_valid (zen_valid),
		.out_x     (zen_x),
		.out_y     (zen_y),
		.out_ang   (zen_ang),
		.out_dirs  (zen_dirs),
		.out_side  (zen_side)
	);

	// clamp the zenith angle and scale by the image radius
	always_comb begin
		if (zen_side.zero || zen_ang[ANG_W-1]) begin
			zd = 31'd0;
		end else if (zen_ang > QUARTER_TURN) begin
			zd = QUARTER_TURN[30:0];
		end else begin
			zd = zen_ang[30:0];
		end
		cc     = cols_q[DIM_W-1:1];
		cr     = rows_q[DIM_W-1:1];
		radius = (cr < cc) ? cr : cc;
		prod_p = zd * radius;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= zen_valid;
		end
	end

	always_ff @(posedge clk) begin
		p_s3    <= prod_p[42:14];
		dirs_s3 <= zen_dirs;
		side_s3 <= zen_side;
	end

	// rotate (p, 0) back through the recorded azimuth turns
	sdp_cordic_chain #(.W(ROT_W), .N(N), .MODE(MODE_ROT)) u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.in_x      ($signed({1'b0, p_s3})),
		.in_y      ('0),
		.in_ang    ('0),
		.in_dirs   (dirs_s3),
		.in_side   (side_s3),
		.out_valid (rot_valid),
		.out_x     (rot_x),
		.out_y     (rot_y),
		.out_ang   (rot_ang),
		.out_dirs  (rot_dirs),
		.out_side  (rot_side)
	);

	// undo the fold and multiply by the gain correction
	always_comb begin
		fx = rot_side.flip ? -rot_x : rot_x;
		fy = rot_side.flip ? -rot_y : rot_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= rot_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_x_s4 <= fx * KINV_S;
		prod_y_s4 <= fy * KINV_S;
		side_s4   <= rot_side;
	end

	// offsets from the centre, clamped into the image
	always_comb begin
		offc  = trunc46(prod_x_s4);
		offr  = trunc46(prod_y_s4);
		col_v = $signed({4'b0, cols_q[DIM_W-1:1]}) + offc;
		row_v = $signed({4'b0, rows_q[DIM_W-1:1]}) - offr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		fb_q    <= side_s4.fallback;
		col_q   <= side_s4.fallback ? '0 : clamp_index(col_v, cols_q);
		row_q   <= side_s4.fallback ? '0 : clamp_index(row_v, rows_q);
		color_q <= side_s4.fallback ? rgb_q : '0;
	end

	assign done           = done_q;
	assign use_fallback   = fb_q;
	assign pixel_column   = col_q;
	assign pixel_row      = row_q;
	assign fallback_color = color_q;

	// every item leaving the last multiply stage is reported next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |=> done)
		else $error("result lost after gain stage");

	// background results carry no pixel
	a_fallback_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && use_fallback |-> pixel_column == '0 && pixel_row == '0)
		else $error("background result with pixel index");

	// pixel results carry no colour
	a_pixel_no_color: assert property (@(posedge clk) disable iff (!arst_n)
		done && !use_fallback |-> fallback_color == '0)
		else $error("pixel result with background colour");

endmodule

[rtl/core/sdp_cordic_cell.sv]
// one CORDIC micro-rotation cell with its output register
// depends on sdp_pkg for the angle table, modes and side flags
module sdp_cordic_cell import sdp_pkg::*; #(
	parameter int           W     = AZ_W,
	parameter int           NDIR  = CORDIC_STAGES_DEF,
	parameter int           STAGE = 0,
	parameter cordic_mode_t MODE  = MODE_AZ
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [W-1:0]     in_x,
	input  logic signed [W-1:0]     in_y,
	input  logic signed [ANG_W-1:0] in_ang,
	input  logic [NDIR-1:0]         in_dirs,
	input  side_t                   in_side,
	output logic                    out_valid,
	output logic signed [W-1:0]     out_x,
	output logic signed [W-1:0]     out_y,
	output logic signed [ANG_W-1:0] out_ang,
	output logic [NDIR-1:0]         out_dirs,
	output side_t                   out_side
);

	logic signed [W-1:0]     xs, ys, nx, ny;
	logic signed [ANG_W-1:0] step, nang;
	logic [NDIR-1:0]         ndirs;
	logic                    sub;
	logic                    valid_q;
	logic signed [W-1:0]     x_q, y_q;
	logic signed [ANG_W-1:0] ang_q;
	logic [NDIR-1:0]         dirs_q;
	side_t                   side_q;

	// micro-rotation: direction from the sign of y or from the stored turn
	always_comb begin
		xs    = in_x >>> STAGE;
		ys    = in_y >>> STAGE;
		step  = $signed({1'b0, ATAN_TAB[STAGE]});
		ndirs = in_dirs;
		nang  = in_ang;
		case (MODE)
			MODE_AZ: begin
				sub = in_y[W-1];
				ndirs[STAGE] = ~in_y[W-1];
			end
			MODE_ZEN: begin
				sub  = in_y[W-1];
				nang = in_y[W-1] ? in_ang - step : in_ang + step;
			end
			MODE_ROT: begin
				sub = in_dirs[STAGE];
			end
			default: begin
				sub = 1'b0;
			end
		endcase
		nx = sub ? in_x - ys : in_x + ys;
		ny = sub ? in_y + xs : in_y - xs;
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	// vector and side data
	always_ff @(posedge clk) begin
		x_q    <= nx;
		y_q    <= ny;
		ang_q  <= nang;
		dirs_q <= ndirs;
		side_q <= in_side;
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_ang   = ang_q;
	assign out_dirs  = dirs_q;
	assign out_side  = side_q;

endmodule

[rtl/core/sdp_cordic_chain.sv]
// row of CORDIC cells, one per micro-rotation, each handing on every cycle
// depends on sdp_pkg and sdp_cordic_cell
module sdp_cordic_chain import sdp_pkg::*; #(
	parameter int           W    = AZ_W,
	parameter int           N    = CORDIC_STAGES_DEF,
	parameter cordic_mode_t MODE = MODE_AZ
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [W-1:0]     in_x,
	input  logic signed [W-1:0]     in_y,
	input  logic signed [ANG_W-1:0] in_ang,
	input  logic [N-1:0]            in_dirs,
	input  side_t                   in_side,
	output logic                    out_valid,
	output logic signed [W-1:0]     out_x,
	output logic signed [W-1:0]     out_y,
	output logic signed [ANG_W-1:0] out_ang,
	output logic [N-1:0]            out_dirs,
	output side_t                   out_side
);

	logic                    valid_w [0:N];
	logic signed [W-1:0]     x_w     [0:N];
	logic signed [W-1:0]     y_w     [0:N];
	logic signed [ANG_W-1:0] ang_w   [0:N];
	logic [N-1:0]            dirs_w  [0:N];
	side_t                   side_w  [0:N];

	// chain entry
	assign valid_w[0] = in_valid;
	assign x_w[0]     = in_x;
	assign y_w[0]     = in_y;
	assign ang_w[0]   = in_ang;
	assign dirs_w[0]  = in_dirs;
	assign side_w[0]  = in_side;

	// one cell per micro-rotation
	for (genvar i = 0; i < N; i++) begin : g_cell
		sdp_cordic_cell #(
			.W     (W),
			.NDIR  (N),
			.STAGE (i),
			.MODE  (MODE)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_w[i]),
			.in_x      (x_w[i]),
			.in_y      (y_w[i]),
			.in_ang    (ang_w[i]),
			.in_dirs   (dirs_w[i]),
			.in_side   (side_w[i]),
			.out_valid (valid_w[i+1]),
			.out_x     (x_w[i+1]),
			.out_y     (y_w[i+1]),
			.out_ang   (ang_w[i+1]),
			.out_dirs  (dirs_w[i+1]),
			.out_side  (side_w[i+1])
		);
	end

	// chain exit
	assign out_valid = valid_w[N];
	assign out_x     = x_w[N];
	assign out_y     = y_w[N];
	assign out_ang   = ang_w[N];
	assign out_dirs  = dirs_w[N];
	assign out_side  = side_w[N];

endmodule
